FILE: hw/rtl/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants for the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int SIZE_W     = 16;
    localparam int TOTAL_W    = 20;
    localparam int CFG_W      = 5;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_ALLOC = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LD_RD,
        ST_LD_WR,
        ST_SCAN,
        ST_SCAN_END,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [SIZE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed
    {
        logic               granted;
        logic [IDX_W-1:0]   chosen;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

FILE: hw/rtl/wfba_mem.sv
// ----------------------------------------------------------------------------
// wfba_mem
// Free-size store: one write and one registered read port, per-entry valid
// bits so that entries never written read as zero after reset.
// ----------------------------------------------------------------------------
module wfba_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wfba_pkg::mem_req_t            req,
    output logic [wfba_pkg::SIZE_W-1:0]   rd_data
);

    logic [wfba_pkg::SIZE_W-1:0]     mem_arr [wfba_pkg::NUM_BLOCKS];
    logic [wfba_pkg::NUM_BLOCKS-1:0] valid_reg;
    logic [wfba_pkg::SIZE_W-1:0]     rd_word_reg;
    logic                            rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_arr[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_word_reg <= mem_arr[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rd_ok_reg <= valid_reg[req.raddr];
            end
        end
    end

    // unwritten entries read as zero through their cleared valid bit
    assign rd_data = rd_ok_reg ? rd_word_reg : '0;

endmodule

FILE: hw/rtl/wfba_ctrl.sv
// ----------------------------------------------------------------------------
// wfba_ctrl
// Sequencer: load read-modify-write, worst-fit scan over the store, write-back
// of the reduced size and upkeep of the running free total.
// ----------------------------------------------------------------------------
module wfba_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wfba_pkg::cmd_t                in_cmd,
    input  logic [wfba_pkg::IDX_W-1:0]    in_index,
    input  logic [wfba_pkg::SIZE_W-1:0]   in_amount,
    input  logic [wfba_pkg::CFG_W-1:0]    block_count,
    output wfba_pkg::mem_req_t            mem_req,
    input  logic [wfba_pkg::SIZE_W-1:0]   rd_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output wfba_pkg::result_t             res
);

    wfba_pkg::state_t state_reg, state_next;

    logic [wfba_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [wfba_pkg::SIZE_W-1:0]  amt_reg, amt_next;
    logic [wfba_pkg::CNT_W-1:0]   n_reg, n_next;
    logic [wfba_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [wfba_pkg::IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                         found_reg, found_next;
    logic [wfba_pkg::IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [wfba_pkg::SIZE_W-1:0]  best_val_reg, best_val_next;
    logic [wfba_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic                         granted_reg, granted_next;
    logic [wfba_pkg::IDX_W-1:0]   chosen_reg, chosen_next;

    logic                         accept;
    logic [wfba_pkg::CNT_W-1:0]   n_in;

    assign accept = in_valid && in_ready;
    assign n_in   = (wfba_pkg::CNT_W'(block_count) > wfba_pkg::CNT_W'(wfba_pkg::NUM_BLOCKS))
                    ? wfba_pkg::CNT_W'(wfba_pkg::NUM_BLOCKS)
                    : wfba_pkg::CNT_W'(block_count);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wfba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == wfba_pkg::CMD_LOAD)
                        state_next = wfba_pkg::ST_LD_RD;
                    else if (n_in == '0)
                        state_next = wfba_pkg::ST_WRITE;
                    else
                        state_next = wfba_pkg::ST_SCAN;
                end
            end
            wfba_pkg::ST_LD_RD:    state_next = wfba_pkg::ST_LD_WR;
            wfba_pkg::ST_LD_WR:    state_next = wfba_pkg::ST_DONE;
            wfba_pkg::ST_SCAN:
            begin
                if (cnt_reg == n_reg - wfba_pkg::CNT_W'(1))
                    state_next = wfba_pkg::ST_SCAN_END;
            end
            wfba_pkg::ST_SCAN_END: state_next = wfba_pkg::ST_WRITE;
            wfba_pkg::ST_WRITE:    state_next = wfba_pkg::ST_DONE;
            wfba_pkg::ST_DONE:
            begin
                if (res_ready)
                    state_next = wfba_pkg::ST_IDLE;
            end
            default:               state_next = wfba_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_req   = '0;
        unique case (state_reg)
            wfba_pkg::ST_IDLE:     in_ready = 1'b1;
            wfba_pkg::ST_LD_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = idx_reg;
            end
            wfba_pkg::ST_LD_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = amt_reg;
            end
            wfba_pkg::ST_SCAN:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cnt_reg[wfba_pkg::IDX_W-1:0];
            end
            wfba_pkg::ST_SCAN_END: ;
            wfba_pkg::ST_WRITE:
            begin
                mem_req.we    = found_reg;
                mem_req.waddr = best_idx_reg;
                mem_req.wdata = best_val_reg - amt_reg;
            end
            wfba_pkg::ST_DONE:     res_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        idx_next      = idx_reg;
        amt_next      = amt_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        total_next    = total_reg;
        granted_next  = granted_reg;
        chosen_next   = chosen_reg;

        if (accept)
        begin
            idx_next   = in_index;
            amt_next   = in_amount;
            n_next     = n_in;
            cnt_next   = '0;
            found_next = 1'b0;
        end

        if (state_reg == wfba_pkg::ST_SCAN)
        begin
            cnt_next    = cnt_reg + wfba_pkg::CNT_W'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = cnt_reg[wfba_pkg::IDX_W-1:0];
        end

        // strictly larger wins, so ties keep the lowest index
        if (rd_vld_reg && (rd_data >= amt_reg) && (!found_reg || (rd_data > best_val_reg)))
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_val_next = rd_data;
        end

        if (state_reg == wfba_pkg::ST_LD_WR)
        begin
            total_next   = total_reg - wfba_pkg::TOTAL_W'(rd_data)
                           + wfba_pkg::TOTAL_W'(amt_reg);
            granted_next = 1'b1;
            chosen_next  = idx_reg;
        end

        if (state_reg == wfba_pkg::ST_WRITE)
        begin
            granted_next = found_reg;
            chosen_next  = found_reg ? best_idx_reg : '0;
            if (found_reg)
                total_next = total_reg - wfba_pkg::TOTAL_W'(amt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wfba_pkg::ST_IDLE;
            rd_vld_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        amt_reg      <= amt_next;
        n_reg        <= n_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        granted_reg  <= granted_next;
        chosen_reg   <= chosen_next;
    end

    assign res.granted = granted_reg;
    assign res.chosen  = chosen_reg;
    assign res.total   = total_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfba_pkg::ST_SCAN) |-> (cnt_reg < n_reg))
        else $error("scan index past block count");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> !mem_req.re)
        else $error("store read and write in one cycle");

    a_fit_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wfba_pkg::ST_WRITE && found_reg) |-> (best_val_reg >= amt_reg))
        else $error("chosen block smaller than request");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result changed while waiting");

endmodule

FILE: hw/rtl/worst_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit allocator over a table of block free sizes with a running total.
//
//  channel   direction  fields (low bit first)
//  s_*       in         tuser: cmd | tdata: block_index[3:0], amount[19:4]
//  m_*       out        tuser: granted | tdata: chosen_block[3:0], total_unused[23:4]
//  cfg_*     in         cfg_wdata: block_count
//
// a load goes from transfer to transfer through read, write and result
// an allocate scans n = min(block_count, 16) entries of the free-size store
// at one entry per cycle through its single read port, then writes back and results;
// with no block in use it skips the scan
// reset clears the store through per-entry valid bits, no clearing pass
// a new item is taken while the previous result waits in the output register
// ----------------------------------------------------------------------------
module worst_fit_block_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // block_index, amount, zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // chosen_block, total_unused
    output logic        m_tuser,   // granted
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata  // block_count
);

    logic [wfba_pkg::CFG_W-1:0] block_count_reg;
    logic                       m_tvalid_reg;
    logic [23:0]                m_tdata_reg;
    logic                       m_tuser_reg;

    wfba_pkg::mem_req_t          mem_req;
    logic [wfba_pkg::SIZE_W-1:0] rd_data;
    logic                        res_valid;
    logic                        res_ready;
    wfba_pkg::result_t           res;
    wfba_pkg::cmd_t              in_cmd;

    assign in_cmd    = wfba_pkg::cmd_t'(s_tuser);
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                block_count_reg <= cfg_wdata;
            if (res_ready)
                m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {res.total, res.chosen};
            m_tuser_reg <= res.granted;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    wfba_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (in_cmd),
        .in_index    (s_tdata[3:0]),
        .in_amount   (s_tdata[19:4]),
        .block_count (block_count_reg),
        .mem_req     (mem_req),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    wfba_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the worst-fit block allocator: drives load and
// allocate transfers with random gaps and stalls, predicts grant, block and
// total from its own free-size table, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 24;

    class alloc_scoreboard;
        logic [wfba_pkg::SIZE_W-1:0] free_size [wfba_pkg::NUM_BLOCKS];
        logic [wfba_pkg::CFG_W-1:0]  block_count;
        wfba_pkg::result_t           expected_grants [$];
        int                          mismatches;

        function new();
            foreach (free_size[i])
                free_size[i] = '0;
            block_count = '0;
            mismatches  = 0;
        endfunction

        function void note_request(input wfba_pkg::cmd_t op,
                                   input logic [wfba_pkg::IDX_W-1:0] idx,
                                   input logic [wfba_pkg::SIZE_W-1:0] amt);
            wfba_pkg::result_t r;
            int                span;
            int                best;
            bit                found;
            longint            sum;
            r = '0;
            if (op == wfba_pkg::CMD_LOAD)
            begin
                if (int'(idx) < wfba_pkg::NUM_BLOCKS)
                begin
                    free_size[idx] = amt;
                    r.granted      = 1'b1;
                    r.chosen       = idx;
                end
            end
            else
            begin
                // block counts beyond the table size are clipped
                span  = (int'(block_count) > wfba_pkg::NUM_BLOCKS)
                        ? wfba_pkg::NUM_BLOCKS : int'(block_count);
                found = 1'b0;
                best  = 0;
                for (int j = 0; j < span; j++)
                begin
                    if (free_size[j] >= amt && (!found || free_size[j] > free_size[best]))
                    begin
                        best  = j;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    free_size[best] = free_size[best] - amt;
                    r.granted       = 1'b1;
                    r.chosen        = wfba_pkg::IDX_W'(best);
                end
            end
            sum = 0;
            foreach (free_size[i])
                sum += free_size[i];
            r.total = (sum > longint'({wfba_pkg::TOTAL_W{1'b1}}))
                      ? '1 : wfba_pkg::TOTAL_W'(sum);
            expected_grants.push_back(r);
        endfunction

        function void check_grant(input logic g, input logic [wfba_pkg::IDX_W-1:0] ch,
                                  input logic [wfba_pkg::TOTAL_W-1:0] tot);
            wfba_pkg::result_t e;
            if (expected_grants.size() == 0)
            begin
                $error("result transfer with nothing expected: granted %0d block %0d total %0d",
                       g, ch, tot);
                mismatches++;
                return;
            end
            e = expected_grants.pop_front();
            if (g !== e.granted)
            begin
                $error("granted: expected %0d, got %0d", e.granted, g);
                mismatches++;
            end
            if (ch !== e.chosen)
            begin
                $error("chosen_block: expected %0d, got %0d", e.chosen, ch);
                mismatches++;
            end
            if (tot !== e.total)
            begin
                $error("total_unused: expected %0d, got %0d", e.total, tot);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    int              cycles        = 0;
    alloc_scoreboard sb            = new();

    always #5 clk = ~clk;

    worst_fit_block_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_grant(m_tuser, m_tdata[3:0], m_tdata[23:4]);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid is lowered only when a gap or a drain starts, so back-to-back transfers keep it high
    task automatic send_item(input wfba_pkg::cmd_t op, input logic [3:0] idx,
                             input logic [15:0] amt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, amt, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, idx, amt);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_grants.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_block_count(input logic [4:0] value);
        drain_results();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.block_count = value;
    endtask

    task automatic run_segment(input int count);
        logic [15:0] amt;
        logic [3:0]  idx;
        for (int k = 0; k < count; k++)
        begin
            idx = 4'($urandom_range(15));
            if ($urandom_range(99) < 35)
            begin
                // copying another entry makes ties likely
                case ($urandom_range(3))
                    0:       amt = sb.free_size[$urandom_range(15)];
                    1:       amt = 16'($urandom_range(4095));
                    default: amt = 16'($urandom());
                endcase
                send_item(wfba_pkg::CMD_LOAD, idx, amt);
            end
            else
            begin
                case ($urandom_range(5))
                    0:       amt = '0;
                    1:       amt = sb.free_size[$urandom_range(15)];
                    2:       amt = sb.free_size[$urandom_range(15)] + 16'($urandom_range(2));
                    3:       amt = 16'($urandom_range(511));
                    default: amt = 16'($urandom());
                endcase
                send_item(wfba_pkg::CMD_ALLOC, idx, amt);
            end
            if ($urandom_range(149) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        int          sender_idle [4];
        int          recv_stall [4];
        logic [4:0]  counts [16];
        int          seg;
        sender_idle = '{0, 68, 0, 36};
        recv_stall  = '{0, 0, 68, 36};
        counts      = '{5'd16, 5'd0, 5'd17, 5'd1, 5'd16, 5'd31, 5'd2, 5'd16,
                        5'd16, 5'd8, 5'd31, 5'd3, 5'd16, 5'd16, 5'd15, 5'd20};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nothing in use yet, so even a zero request is refused
        send_item(wfba_pkg::CMD_ALLOC, 4'd0, 16'h0000);
        write_block_count(5'd31);
        for (int i = 0; i < wfba_pkg::NUM_BLOCKS; i++)
            send_item(wfba_pkg::CMD_LOAD, 4'(i), 16'hFFFF);
        send_item(wfba_pkg::CMD_ALLOC, 4'd9, 16'hFFFF);
        send_item(wfba_pkg::CMD_ALLOC, 4'd6, 16'hFFFF);
        send_item(wfba_pkg::CMD_ALLOC, 4'd0, 16'h0000);
        send_item(wfba_pkg::CMD_ALLOC, 4'd15, 16'h8000);
        send_item(wfba_pkg::CMD_ALLOC, 4'd0, 16'h0001);
        write_block_count(5'd1);
        send_item(wfba_pkg::CMD_ALLOC, 4'd0, 16'hFFFF);
        send_item(wfba_pkg::CMD_ALLOC, 4'hF, 16'h0000);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            send_idle_pct = sender_idle[ph];
            stall_pct     = recv_stall[ph];
            for (int s = 0; s < 4; s++)
            begin
                seg = ph * 4 + s;
                if (s == 3 && ph != 0)
                    write_block_count(5'($urandom_range(31)));
                else
                    write_block_count(counts[seg]);
                run_segment(66);
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.expected_grants.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
